/* src/projection_profile_change_counter_core_macros.svh */
// assertion macros used by the checker file of the change counter core
`ifndef PROJECTION_PROFILE_CHANGE_COUNTER_CORE_MACROS_SVH
`define PROJECTION_PROFILE_CHANGE_COUNTER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define PPCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppcc check failed");

// next-cycle implication, off during reset
`define PPCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppcc check failed");

// next-cycle implication that also watches the reset cycles
`define PPCC_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ppcc check failed");

`endif

/* src/ppcc_pkg.sv */
// types, constants and helper functions of the change counter core
package ppcc_pkg;

   localparam int unsigned PIXEL_W     = 8;
   localparam int unsigned SUM_W       = 16;
   localparam int unsigned THR_W       = 16;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned TOTAL_W     = 9;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [QPTR_W:0] QUEUE_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [THR_W-1:0]   thr_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam sum_type   SUM_MAX   = '1;
   localparam count_type COUNT_MAX = '1;
   localparam thr_type   THR_RESET = thr_type'(255);

   // what an item does to the row bookkeeping
   typedef enum logic [1:0] {
      KIND_PIXEL,
      KIND_ROW_END,
      KIND_IMAGE_END
   } kind_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      kind_type           kind;
   } item_type;

   // saturating add of two profile sums
   function automatic sum_type sat_add(sum_type a, sum_type b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   // absolute difference above threshold
   function automatic logic beyond(sum_type a, sum_type b, thr_type thr);
      sum_type d;
      d = (a > b) ? (a - b) : (b - a);
      return d > thr;
   endfunction

   // saturating increment of a change count
   function automatic count_type sat_inc(count_type c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

endpackage

/* src/projection_profile_change_counter_core.sv */
// top level of the projection profile change counter
//
//   channel  ports                                   handshake
//   req      req_pixel, req_row_end, req_image_end   start high, busy low
//   rsp      rsp_row_changes, rsp_column_changes,    rsp_strobe, one cycle
//            rsp_total_changes
//   csr      csr_data (change threshold)             csr_valid and csr_ready
//
// One pixel is taken per cycle while the four-entry item queue has room.
// The image end costs the column walk, one column memory read per cycle,
// and busy rises once the queue fills behind it.
// The result is registered onto rsp_strobe when the walk ends; it cannot be held.
// Synchronous reset clears all control state and sets the threshold to 255.
module projection_profile_change_counter_core
   import ppcc_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 256
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [PIXEL_W-1:0] req_pixel,
   input  logic               req_row_end,
   input  logic               req_image_end,
   output logic               rsp_strobe,
   output logic [COUNT_W-1:0] rsp_row_changes,
   output logic [COUNT_W-1:0] rsp_column_changes,
   output logic [TOTAL_W-1:0] rsp_total_changes,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [THR_W-1:0]   csr_data
);

   thr_type  threshold_ff;
   item_type item;
   logic     item_valid;
   logic     item_pop;

   // threshold register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // item intake and queue
   ppcc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel     (req_pixel),
      .req_row_end   (req_row_end),
      .req_image_end (req_image_end),
      .item          (item),
      .item_valid    (item_valid),
      .item_pop      (item_pop)
   );

   // profiles, column walk and result
   ppcc_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .threshold          (threshold_ff),
      .item               (item),
      .item_valid         (item_valid),
      .item_pop           (item_pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_row_changes    (rsp_row_changes),
      .rsp_column_changes (rsp_column_changes),
      .rsp_total_changes  (rsp_total_changes)
   );

endmodule

/* src/ppcc_front.sv */
// front end: takes items, classifies them and queues them for the back end
module ppcc_front
   import ppcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [PIXEL_W-1:0] req_pixel,
   input  logic               req_row_end,
   input  logic               req_image_end,
   output item_type           item,
   output logic               item_valid,
   input  logic               item_pop
);

   item_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              push;
   logic              pop;
   item_type          new_item;

   // handshake
   assign busy       = (fill_ff == QUEUE_FULL);
   assign push       = start & ~busy;
   assign item_valid = (fill_ff != '0);
   assign pop        = item_pop & item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   // classify: an image end also closes its row
   always_comb begin
      new_item.pixel = req_pixel;
      if (req_image_end) begin
         new_item.kind = KIND_IMAGE_END;
      end else if (req_row_end) begin
         new_item.kind = KIND_ROW_END;
      end else begin
         new_item.kind = KIND_PIXEL;
      end
   end

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* src/ppcc_back.sv */
// back end: row and column profiles, column walk and result
module ppcc_back
   import ppcc_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 256
)
(
   input  logic               clock,
   input  logic               reset,
   input  thr_type            threshold,
   input  item_type           item,
   input  logic               item_valid,
   output logic               item_pop,
   output logic               rsp_strobe,
   output logic [COUNT_W-1:0] rsp_row_changes,
   output logic [COUNT_W-1:0] rsp_column_changes,
   output logic [TOTAL_W-1:0] rsp_total_changes
);

   localparam int unsigned POS_W  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_WIDTH);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DRAIN,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;

   // per-image state
   sum_type          running_ff, running_in;
   sum_type          prev_row_ff, prev_row_in;
   logic             first_ff, first_in;
   logic [POS_W-1:0] col_pos_ff, col_pos_in;
   logic [POS_W-1:0] width_ff, width_in;
   count_type        row_cnt_ff, row_cnt_in;

   // column update stage
   logic              b_valid_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   logic [PIXEL_W-1:0] b_px_ff;
   logic              b_over_ff;
   logic              last_valid_ff;
   logic [ADDR_W-1:0] last_addr_ff;
   sum_type           last_data_ff;
   sum_type           b_base;
   sum_type           b_value;

   // column memory
   sum_type           col_mem [MAX_WIDTH];
   sum_type           rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   // column walk
   logic [POS_W-1:0] walk_addr_ff, walk_addr_in;
   logic             walk_rv_ff;
   logic             walk_first_ff;
   logic             walk_issue;
   sum_type          prev_col_ff;
   count_type        col_cnt_ff, col_cnt_in;

   // result
   logic               strobe_in;
   logic [TOTAL_W-1:0] total_in;

   // front side decode
   logic    take;
   logic    row_done;
   logic    img_end;
   logic    in_range;
   logic    overwrite;
   sum_type run_sum;

   assign item_pop  = (state_ff == ST_RUN) && item_valid;
   assign take      = item_pop;
   assign row_done  = (item.kind == KIND_ROW_END) || (item.kind == KIND_IMAGE_END);
   assign img_end   = (item.kind == KIND_IMAGE_END);
   assign in_range  = (col_pos_ff < POS_LIMIT);
   assign overwrite = first_ff | (col_pos_ff >= width_ff);
   assign run_sum   = sat_add(running_ff, SUM_W'(item.pixel));

   assign walk_issue = (state_ff == ST_WALK) && (walk_addr_ff < width_ff);
   assign rd_addr    = (state_ff == ST_WALK) ? walk_addr_ff[ADDR_W-1:0]
                                             : col_pos_ff[ADDR_W-1:0];

   // column sum update, with bypass of the previous write
   assign b_base  = (last_valid_ff && (last_addr_ff == b_addr_ff)) ? last_data_ff
                                                                  : rd_data_ff;
   assign b_value = b_over_ff ? SUM_W'(b_px_ff) : sat_add(b_base, SUM_W'(b_px_ff));

   assign total_in = TOTAL_W'(row_cnt_ff) + TOTAL_W'(col_cnt_ff);

   // next state of the profile bookkeeping and the walk
   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      prev_row_in  = prev_row_ff;
      first_in     = first_ff;
      col_pos_in   = col_pos_ff;
      width_in     = width_ff;
      row_cnt_in   = row_cnt_ff;
      walk_addr_in = walk_addr_ff;
      col_cnt_in   = col_cnt_ff;
      strobe_in    = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (take) begin
               running_in = run_sum;
               if (in_range) begin
                  col_pos_in = col_pos_ff + 1'b1;
                  if (col_pos_ff >= width_ff) begin
                     width_in = col_pos_ff + 1'b1;
                  end
               end
               if (row_done) begin
                  if (!first_ff && beyond(run_sum, prev_row_ff, threshold)) begin
                     row_cnt_in = sat_inc(row_cnt_ff);
                  end
                  prev_row_in = run_sum;
                  running_in  = '0;
                  first_in    = 1'b0;
                  col_pos_in  = '0;
               end
               if (img_end) begin
                  prev_row_in = '0;
                  first_in    = 1'b1;
                  state_in    = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            walk_addr_in = '0;
            col_cnt_in   = '0;
            state_in     = ST_WALK;
         end
         ST_WALK: begin
            if (walk_issue) begin
               walk_addr_in = walk_addr_ff + 1'b1;
            end
            if (walk_rv_ff && !walk_first_ff &&
                beyond(rd_data_ff, prev_col_ff, threshold)) begin
               col_cnt_in = sat_inc(col_cnt_ff);
            end
            if (!walk_issue && !walk_rv_ff) begin
               strobe_in  = 1'b1;
               width_in   = '0;
               row_cnt_in = '0;
               state_in   = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // state machine and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= strobe_in;
      end
      if (strobe_in) begin
         rsp_row_changes    <= row_cnt_ff;
         rsp_column_changes <= col_cnt_ff;
         rsp_total_changes  <= total_in;
      end
   end

   // profile control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= '0;
         prev_row_ff   <= '0;
         first_ff      <= 1'b1;
         col_pos_ff    <= '0;
         width_ff      <= '0;
         row_cnt_ff    <= '0;
         col_cnt_ff    <= '0;
         walk_addr_ff  <= '0;
         walk_rv_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         running_ff    <= running_in;
         prev_row_ff   <= prev_row_in;
         first_ff      <= first_in;
         col_pos_ff    <= col_pos_in;
         width_ff      <= width_in;
         row_cnt_ff    <= row_cnt_in;
         col_cnt_ff    <= col_cnt_in;
         walk_addr_ff  <= walk_addr_in;
         walk_rv_ff    <= walk_issue;
         b_valid_ff    <= take & in_range;
         last_valid_ff <= b_valid_ff;
      end
   end

   // payload of the update stage and the walk
   always_ff @(posedge clock) begin
      b_addr_ff     <= col_pos_ff[ADDR_W-1:0];
      b_px_ff       <= item.pixel;
      b_over_ff     <= overwrite;
      last_addr_ff  <= b_addr_ff;
      last_data_ff  <= b_value;
      walk_first_ff <= (walk_addr_ff == '0);
      if (walk_rv_ff) begin
         prev_col_ff <= rd_data_ff;
      end
   end

   // column sum memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         col_mem[b_addr_ff] <= b_value;
      end
      rd_data_ff <= col_mem[rd_addr];
   end

endmodule

/* src/ppcc_checker.sv */
// port level checks of the change counter core and their bind
`include "projection_profile_change_counter_core_macros.svh"

module ppcc_checker
   import ppcc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [COUNT_W-1:0] rsp_row_changes,
   input logic [COUNT_W-1:0] rsp_column_changes,
   input logic [TOTAL_W-1:0] rsp_total_changes
);

   // total is the sum of the two counts
   `PPCC_ASSERT_NOW(total_is_sum, clock, reset, rsp_strobe, rsp_total_changes == (TOTAL_W'(rsp_row_changes) + TOTAL_W'(rsp_column_changes)))

   // results never come back to back, the walk sits between them
   `PPCC_ASSERT_NEXT(strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

   // reset leaves an empty queue and no result
   `PPCC_ASSERT_ALWAYS_NEXT(reset_quiet, clock, reset, !busy && !rsp_strobe)

endmodule

bind projection_profile_change_counter_core ppcc_checker u_ppcc_checker (
   .clock              (clock),
   .reset              (reset),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_row_changes    (rsp_row_changes),
   .rsp_column_changes (rsp_column_changes),
   .rsp_total_changes  (rsp_total_changes)
);
